[hw/rtl/shsr_pkg.sv]
// Shared types, constants and the microcode program of the step-halving square root.
`timescale 1ns / 1ps
`default_nettype none

package shsr_pkg;

    localparam int WORD_BITS_DEFAULT     = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int          EPS_BITS  = 16;
    localparam logic [15:0] EPS_RESET = 16'd7;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index as carried in paddr[2].
    localparam logic REG_EPSILON = 1'b0;

    localparam int PC_BITS = 3;
    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t PC_IDLE     = 3'd0;
    localparam pc_t PC_SQUARE   = 3'd1;
    localparam pc_t PC_CHECK    = 3'd2;
    localparam pc_t PC_STEPTEST = 3'd3;
    localparam pc_t PC_WSQUARE  = 3'd4;
    localparam pc_t PC_WALK     = 3'd5;
    localparam pc_t PC_DONE     = 3'd6;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_SET_CONV,
        OP_CLR_CONV,
        OP_MOVE,
        OP_FLIP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_WITHIN_TOL,
        COND_STEP_ZERO,
        COND_ON_SIDE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        cond_t cond;
        op_t   op_true;
        op_t   op_false;
        pc_t   jump_true;
        pc_t   jump_false;
    } ucode_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic within_tol;
        logic step_zero;
        logic on_side;
        logic out_free;
    } stat_t;

    // The program: one word per step, branch on the selected condition.
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:     w = '{COND_IN_VALID,   OP_LOAD,     OP_NONE,     PC_SQUARE,  PC_IDLE};
            PC_SQUARE:   w = '{COND_ALWAYS,     OP_SQUARE,   OP_NONE,     PC_CHECK,   PC_CHECK};
            PC_CHECK:    w = '{COND_WITHIN_TOL, OP_SET_CONV, OP_NONE,     PC_DONE,    PC_STEPTEST};
            PC_STEPTEST: w = '{COND_STEP_ZERO,  OP_CLR_CONV, OP_NONE,     PC_DONE,    PC_WSQUARE};
            PC_WSQUARE:  w = '{COND_ALWAYS,     OP_SQUARE,   OP_NONE,     PC_WALK,    PC_WALK};
            PC_WALK:     w = '{COND_ON_SIDE,    OP_MOVE,     OP_FLIP,     PC_WSQUARE, PC_SQUARE};
            PC_DONE:     w = '{COND_OUT_FREE,   OP_EMIT,     OP_NONE,     PC_IDLE,    PC_DONE};
            default:     w = '{COND_ALWAYS,     OP_NONE,     OP_NONE,     PC_IDLE,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/shsr_if.sv]
// Request channel interfaces for operands and results.
`timescale 1ns / 1ps
`default_nettype none

interface shsr_in_if
    import shsr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface shsr_out_if
    import shsr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] root;
    logic                 converged;

    modport source (output valid, output root, output converged, input ready);
    modport sink   (input valid, input root, input converged, output ready);
endinterface

`default_nettype wire

[hw/rtl/shsr_apb_regs.sv]
// APB configuration register block holding epsilon.
`timescale 1ns / 1ps
`default_nettype none

module shsr_apb_regs
    import shsr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic      [EPS_BITS-1:0]      epsilon
);

    logic [EPS_BITS-1:0] eps_reg;
    logic [EPS_BITS-1:0] eps_next;
    logic                wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_EPSILON);

    always_comb
    begin
        eps_next = eps_reg;
        if (wr_hit)
        begin
            eps_next = pwdata[EPS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else
        begin
            eps_reg <= eps_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_EPSILON)
        begin
            prdata = {{(APB_DATA_BITS-EPS_BITS){1'b0}}, eps_reg};
        end
    end

    assign epsilon = eps_reg;

endmodule

`default_nettype wire

[hw/rtl/shsr_sequencer.sv]
// Microcode sequencer: program counter, condition select and branch.
`timescale 1ns / 1ps
`default_nettype none

module shsr_sequencer
    import shsr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t word;
    logic   hit;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:     hit = 1'b1;
            COND_IN_VALID:   hit = in_valid;
            COND_WITHIN_TOL: hit = stat.within_tol;
            COND_STEP_ZERO:  hit = stat.step_zero;
            COND_ON_SIDE:    hit = stat.on_side;
            COND_OUT_FREE:   hit = stat.out_free;
            default:         hit = 1'b0;
        endcase
    end

    assign pc_next   = hit ? word.jump_true : word.jump_false;
    assign ctrl.op   = hit ? word.op_true : word.op_false;
    assign ctrl.idle = (pc_reg == PC_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/shsr_datapath.sv]
// Datapath: root, step, direction, squarer, error compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module shsr_datapath
    import shsr_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_t                ctrl,
    input  wire logic [WORD_BITS-1:0] number,
    input  wire logic [EPS_BITS-1:0]  epsilon,
    input  wire logic                 out_ready,
    output stat_t                     stat,
    output logic                      out_valid,
    output logic      [WORD_BITS-1:0] out_root,
    output logic                      out_converged
);

    localparam int HALF_BITS = (WORD_BITS + FRACTION_BITS + 1) / 2;
    // Root must hold the square root of the target plus one overshoot of 1.0.
    localparam int ROOT_BITS = ((HALF_BITS > FRACTION_BITS) ? HALF_BITS : FRACTION_BITS) + 2;
    localparam int STEP_BITS = FRACTION_BITS + 1;
    localparam int SQ_BITS   = 2 * ROOT_BITS;
    localparam int TGT_BITS  = WORD_BITS + FRACTION_BITS;
    localparam int TOL_BITS  = EPS_BITS + FRACTION_BITS;
    localparam int CMP_BITS  = (SQ_BITS > TOL_BITS) ? SQ_BITS : TOL_BITS;
    localparam int SAT_BITS  = ((ROOT_BITS > WORD_BITS) ? ROOT_BITS : WORD_BITS) + 1;

    localparam logic [ROOT_BITS-1:0] ROOT_ONE = ROOT_BITS'(1) << FRACTION_BITS;
    localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRACTION_BITS;
    localparam logic [SAT_BITS-1:0]  WORD_MAX = SAT_BITS'({WORD_BITS{1'b1}});

    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] root_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic                 down_reg;
    logic                 down_next;
    logic                 conv_reg;
    logic                 conv_next;
    logic [TGT_BITS-1:0]  target_reg;
    logic [TGT_BITS-1:0]  target_next;
    logic [TOL_BITS-1:0]  tol_reg;
    logic [TOL_BITS-1:0]  tol_next;
    logic [SQ_BITS-1:0]   sq_reg;
    logic [SQ_BITS-1:0]   sq_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] out_root_reg;
    logic [WORD_BITS-1:0] out_root_next;
    logic                 out_conv_reg;
    logic                 out_conv_next;

    logic [SQ_BITS-1:0]   target_ext;
    logic [ROOT_BITS-1:0] step_ext;
    logic [CMP_BITS-1:0]  err;
    logic [SAT_BITS-1:0]  root_sat;

    assign target_ext = SQ_BITS'(target_reg);
    assign step_ext   = ROOT_BITS'(step_reg);
    assign err        = (sq_reg >= target_ext) ? CMP_BITS'(sq_reg - target_ext)
                                               : CMP_BITS'(target_ext - sq_reg);
    assign root_sat   = SAT_BITS'(root_reg);

    assign stat.within_tol = (err <= CMP_BITS'(tol_reg));
    assign stat.step_zero  = (step_reg == '0);
    assign stat.on_side    = down_reg ? (sq_reg > target_ext) : (sq_reg < target_ext);
    assign stat.out_free   = !out_valid_reg;

    always_comb
    begin
        root_next      = root_reg;
        step_next      = step_reg;
        down_next      = down_reg;
        conv_next      = conv_reg;
        target_next    = target_reg;
        tol_next       = tol_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        out_root_next  = out_root_reg;
        out_conv_next  = out_conv_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                root_next   = ROOT_ONE;
                step_next   = STEP_ONE;
                down_next   = 1'b0;
                target_next = TGT_BITS'(number) << FRACTION_BITS;
                tol_next    = TOL_BITS'(epsilon) << FRACTION_BITS;
            end
            OP_SQUARE:
            begin
                sq_next = SQ_BITS'(root_reg) * SQ_BITS'(root_reg);
            end
            OP_SET_CONV:
            begin
                conv_next = 1'b1;
            end
            OP_CLR_CONV:
            begin
                conv_next = 1'b0;
            end
            OP_MOVE:
            begin
                if (!down_reg)
                begin
                    root_next = root_reg + step_ext;
                end
                else if (root_reg >= step_ext)
                begin
                    root_next = root_reg - step_ext;
                end
                else
                begin
                    root_next = '0;
                end
            end
            OP_FLIP:
            begin
                down_next = !down_reg;
                step_next = step_reg >> 1;
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_conv_next  = conv_reg;
                out_root_next  = (root_sat > WORD_MAX) ? {WORD_BITS{1'b1}}
                                                       : root_sat[WORD_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            step_reg      <= '0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            root_reg      <= root_next;
            step_reg      <= step_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_reg     <= conv_next;
        target_reg   <= target_next;
        tol_reg      <= tol_next;
        sq_reg       <= sq_next;
        out_root_reg <= out_root_next;
        out_conv_reg <= out_conv_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_root      = out_root_reg;
    assign out_converged = out_conv_reg;

    // A result is only written into an empty output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT) |-> !out_valid_reg)
        else $error("result written over a pending result");

    // An upward move always grows the root.
    a_move_up: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_MOVE && !down_reg) |=> (root_reg > $past(root_reg)))
        else $error("upward move did not grow the root");

    // A direction flip halves the step.
    a_flip_halves: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_FLIP) |=> (step_reg == ($past(step_reg) >> 1)))
        else $error("step not halved at direction flip");

    // New operands are loaded only while the sequencer is idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_LOAD) |-> ctrl.idle)
        else $error("operand loaded outside idle");

endmodule

`default_nettype wire

[hw/rtl/step_halving_square_root_top.sv]
// Top level of the step-halving square root: channels, APB registers, sequencer, datapath.
//
// Usage: operands arrive on in_ch (valid/ready request channel, field number, unsigned
// fixed point with FRACTION_BITS fraction bits); each request yields exactly one result
// on out_ch (fields root and converged) in the same format.
// Epsilon is written over the APB port at byte address 0; the user is bound to write it
// only while the block is idle, which the block itself does not enforce.
// Timing: one control word per cycle. Each pass of the search squares the root and
// checks the error, tests the step, then walks: each walk move squares and moves, and
// the walk ends with one more square and a direction flip that starts the next pass.
// An operand near the top of the Q16.16 range (root near 256.0) needs about 280 moves
// and 17 flips.
// in_ch.ready is high only while the sequencer is idle, so one item is in work at a time.
// The result sits in an output register; the next operand is accepted while it waits.
// If the receiver stalls with a result still held, a finished item waits in its final
// step until the register drains.
// Reset (rst_n, asynchronous, active low) empties the result register, returns the
// sequencer to idle and sets epsilon to 7.
`timescale 1ns / 1ps
`default_nettype none

module step_halving_square_root_top
    import shsr_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    shsr_in_if.sink                       in_ch,
    shsr_out_if.source                    out_ch,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [EPS_BITS-1:0] epsilon;
    ctrl_t               ctrl;
    stat_t               stat;

    shsr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .epsilon (epsilon)
    );

    shsr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    shsr_datapath #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .number        (in_ch.number),
        .epsilon       (epsilon),
        .out_ready     (out_ch.ready),
        .stat          (stat),
        .out_valid     (out_ch.valid),
        .out_root      (out_ch.root),
        .out_converged (out_ch.converged)
    );

    assign in_ch.ready = ctrl.idle;

endmodule

`default_nettype wire

[sim/step_halving_square_root_top_test.sv]
// Self-checking testbench for the step-halving square root over its request channels and APB port.
`timescale 1ns / 1ps

module step_halving_square_root_top_test;
    import shsr_pkg::*;

    localparam int WORD       = WORD_BITS_DEFAULT;
    localparam int FRAC       = FRACTION_BITS_DEFAULT;
    localparam int MAX_WAIT   = 13;
    localparam int DRAIN_WAIT = 600;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int PHASE_LEN  = 150;

    typedef struct packed {
        logic [WORD-1:0] number;
        logic [WORD-1:0] root;
        logic            converged;
    } root_expect_t;

    logic clk;
    logic rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    shsr_in_if  #(.WORD_BITS(WORD)) in_ch ();
    shsr_out_if #(.WORD_BITS(WORD)) out_ch ();

    step_halving_square_root_top #(
        .WORD_BITS     (WORD),
        .FRACTION_BITS (FRAC)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state, kept apart from the block.
    logic [EPS_BITS-1:0] eps_setting;
    logic [32:0]         search_root;
    logic [16:0]         search_step;
    logic                search_down;

    logic [WORD-1:0] number_q[$];
    root_expect_t    root_expect_q[$];

    int  cycle_count;
    int  items_sent;
    int  roots_checked;
    int  converged_seen;
    int  mismatches;
    int  eps_writes;
    int  hold_left;
    bit  tx_eager;
    bit  rx_eager;
    bit  offering;
    bit  in_taken;
    bit  out_taken;
    int  tx_gap;
    int  rx_wait;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic root_expect_t predict_root(input logic [WORD-1:0] num);
        logic [63:0]  target;
        logic [63:0]  tol;
        logic [63:0]  sq;
        logic [63:0]  err;
        root_expect_t e;
        target = {32'd0, num} << FRAC;
        tol    = {48'd0, eps_setting} << FRAC;
        search_root = 33'd1 << FRAC;
        search_step = 17'd1 << FRAC;
        search_down = 1'b0;
        e.number = num;
        while (1)
        begin
            sq  = {31'd0, search_root} * {31'd0, search_root};
            err = (sq >= target) ? sq - target : target - sq;
            if (err <= tol)
            begin
                e.converged = 1'b1;
                break;
            end
            if (search_step == '0)
            begin
                e.converged = 1'b0;
                break;
            end
            while (1)
            begin
                sq = {31'd0, search_root} * {31'd0, search_root};
                if (!search_down && sq < target)
                    search_root = search_root + search_step;
                else if (search_down && sq > target)
                    search_root = (search_root >= search_step) ?
                                  search_root - search_step : '0;
                else
                    break;
            end
            search_down = !search_down;
            search_step = search_step >> 1;
        end
        e.root = search_root[32] ? '1 : search_root[WORD-1:0];
        return e;
    endfunction

    function automatic logic [WORD-1:0] random_number();
        int unsigned pick;
        int unsigned r;
        pick = $urandom_range(0, 9);
        r    = $urandom_range(0, 255);
        case (pick)
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 32'h000F_FFFF);
            7:          return (r * r) << FRAC;
            8:          return r;
            default:    return 32'hFFFF_FFFF - $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Request side: record accepted operands and predict their roots.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            root_expect_q.push_back(predict_root(in_ch.number));
            items_sent++;
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                offering = 1'b0;
                tx_gap   = tx_eager ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!offering)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (number_q.size() > 0)
                begin
                    in_ch.number <= number_q.pop_front();
                    offering = 1'b1;
                end
            end
            in_ch.valid <= offering;
        end
    end

    // Result side: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        root_expect_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            out_taken = 1'b1;
            if (out_ch.converged)
                converged_seen++;
            if (root_expect_q.size() == 0)
                note_mismatch($sformatf("result root=%h converged=%b with no request pending",
                                        out_ch.root, out_ch.converged));
            else
            begin
                e = root_expect_q.pop_front();
                roots_checked++;
                if (out_ch.root !== e.root)
                    note_mismatch($sformatf("number %h: root expected %h, got %h",
                                            e.number, e.root, out_ch.root));
                if (out_ch.converged !== e.converged)
                    note_mismatch($sformatf("number %h: converged expected %b, got %b",
                                            e.number, e.converged, out_ch.converged));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                rx_wait   = rx_eager ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ch.ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [EPS_BITS-1:0] data,
                              output logic [APB_DATA_BITS-1:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_EPSILON, 2'b00};
        pwdata  <= {{(APB_DATA_BITS-EPS_BITS){1'b0}}, data};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_epsilon();
        logic [APB_DATA_BITS-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[EPS_BITS-1:0] !== eps_setting)
            note_mismatch($sformatf("epsilon read back %h, expected %h",
                                    rd[EPS_BITS-1:0], eps_setting));
    endtask

    task automatic set_epsilon(input logic [EPS_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] rd;
        apb_access(1'b1, value, rd);
        eps_setting = value;
        eps_writes++;
        check_epsilon();
    endtask

    // Idle means nothing queued, nothing offered and every root back.
    task automatic wait_drained();
        while (number_q.size() > 0 || offering || root_expect_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [EPS_BITS-1:0] eps_plan[5];
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.number = '0;
        out_ch.ready = 1'b0;
        eps_setting  = EPS_RESET;
        tx_eager     = 1'b0;
        rx_eager     = 1'b0;
        hold_left    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_epsilon();

        // Zero, the smallest step, exact squares, irrational roots and the top of the range.
        number_q.push_back(32'h0000_0000);
        number_q.push_back(32'h0000_0001);
        number_q.push_back(32'h0000_0002);
        number_q.push_back(32'h0000_8000);
        number_q.push_back(32'h0000_FFFF);
        number_q.push_back(32'h0001_0000);
        number_q.push_back(32'h0001_0001);
        number_q.push_back(32'h0002_0000);
        number_q.push_back(32'h0004_0000);
        number_q.push_back(32'h0009_0000);
        number_q.push_back(32'h0100_0000);
        number_q.push_back(32'h5555_5555);
        number_q.push_back(32'hAAAA_AAAA);
        number_q.push_back(32'h8000_0000);
        number_q.push_back(32'hFFFF_0000);
        number_q.push_back(32'hFFFF_FFFF);
        wait_drained();

        eps_plan[0] = 16'd0;
        eps_plan[1] = 16'hFFFF;
        eps_plan[2] = EPS_RESET;
        eps_plan[3] = 16'($urandom_range(1, 64));
        eps_plan[4] = 16'($urandom);

        for (int p = 0; p < 5; p++)
        begin
            set_epsilon(eps_plan[p]);
            tx_eager = (p == 0) || ($urandom_range(0, 3) == 0);
            rx_eager = (p == 0) || ($urandom_range(0, 3) == 0);
            if (p == 3)
            begin
                // The sender stops until every root of the first half is back.
                repeat (PHASE_LEN / 2) number_q.push_back(random_number());
                wait_drained();
                repeat (PHASE_LEN / 2) number_q.push_back(random_number());
            end
            else
            begin
                repeat (PHASE_LEN) number_q.push_back(random_number());
                if (p == 2)
                begin
                    // The receiver stalls while operands keep coming, so the block backs up.
                    @(negedge clk);
                    hold_left = 1500;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (root_expect_q.size() > 0)
            note_mismatch($sformatf("%0d roots never arrived", root_expect_q.size()));

        $display("Sent %0d operands over %0d epsilon writes, checked %0d roots (%0d converged).",
                 items_sent, eps_writes, roots_checked, converged_seen);
        $display("Mismatches: %0d, run length %0d cycles.", mismatches, cycle_count);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
